>>> rtl/hcbp_pkg.sv
// Package with the shared types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned STORE_BITS   = 32;
  localparam int unsigned CODE_CAP     = (MAX_CODE_LEN < STORE_BITS) ? MAX_CODE_LEN : STORE_BITS;

  localparam int unsigned CODE_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PEND_W      = 7;
  localparam int unsigned ACC_W       = PEND_W + CODE_CAP;
  localparam int unsigned TOT_W       = $clog2(ACC_W + 1);

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_tail_info;
    logic [3:0]        valid_bits;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // Work handed from the front to the back: a masked code to append, or a flush.
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } cmd_t;

endpackage

>>> rtl/hcbp_front.sv
// Front end: accepts words, owns the code table, and turns encodes and flushes into commands.
`timescale 1ns / 1ps

module hcbp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  hcbp_pkg::in_word_t in_i,
  input  logic             cmd_full_i,
  output logic             cmd_push_o,
  output hcbp_pkg::cmd_t   cmd_o
);

  hcbp_pkg::tbl_entry_t tbl_mem [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::TABLE_DEPTH-1:0] vld_q;

  hcbp_pkg::tbl_entry_t rd_q;
  hcbp_pkg::tbl_entry_t wr_entry;
  logic                 rd_vld_q;
  logic                 s1_vld_q, s1_vld_d;
  logic [1:0]           s1_op_q;
  logic                 accept;
  logic                 is_load;
  logic                 need_push;
  logic                 s1_leave;
  logic [hcbp_pkg::LEN_W-1:0]  s1_len;
  logic [hcbp_pkg::CODE_W-1:0] s1_mask;

  assign is_load = (in_i.operation == hcbp_pkg::OP_LOAD);

  always_comb begin
    wr_entry.code = in_i.code_bits;
    if (in_i.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_CAP)) begin
      wr_entry.len = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_CAP);
    end else begin
      wr_entry.len = in_i.code_length;
    end
  end

  // Entries whose valid bit is clear read as having no code.
  assign s1_len = rd_vld_q ? rd_q.len : '0;

  always_comb begin
    if (s1_len >= hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W)) begin
      s1_mask = '1;
    end else begin
      s1_mask = (hcbp_pkg::CODE_W'(1) << s1_len) - hcbp_pkg::CODE_W'(1);
    end
  end

  always_comb begin
    case (s1_op_q)
      hcbp_pkg::OP_ENCODE: need_push = (s1_len != '0);
      hcbp_pkg::OP_FLUSH:  need_push = 1'b1;
      default:             need_push = 1'b0;
    endcase
  end

  assign full_o     = s1_vld_q && need_push && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = s1_vld_q && need_push && !cmd_full_i;
  assign s1_leave   = s1_vld_q && !full_o;

  always_comb begin
    cmd_o.is_flush = (s1_op_q == hcbp_pkg::OP_FLUSH);
    cmd_o.len      = s1_len;
    cmd_o.code     = rd_q.code & s1_mask;
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_leave) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (is_load) begin
        tbl_mem[in_i.symbol] <= wr_entry;
      end else begin
        rd_q <= tbl_mem[in_i.symbol];
      end
      rd_vld_q <= vld_q[in_i.symbol];
      s1_op_q  <= in_i.operation;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (accept && is_load) begin
        vld_q[in_i.symbol] <= 1'b1;
      end
    end
  end

  a_full_needs_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> s1_vld_q)
    else $error("front reports full with an empty stage");

  a_stall_holds_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> s1_vld_q && $stable(s1_op_q))
    else $error("stalled front stage lost its word");

endmodule

>>> rtl/hcbp_cmd_fifo.sv
// Short command queue between the front end and the bit packing back end.
`timescale 1ns / 1ps

module hcbp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hcbp_pkg::cmd_t data_o
);

  hcbp_pkg::cmd_t slot_q [hcbp_pkg::CMD_DEPTH];
  logic [hcbp_pkg::CMD_PTR_W-1:0] wr_q, rd_q;
  logic [hcbp_pkg::CMD_PTR_W:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (hcbp_pkg::CMD_PTR_W+1)'(hcbp_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (hcbp_pkg::CMD_PTR_W+1)'(hcbp_pkg::CMD_DEPTH))
    else $error("command queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[hcbp_pkg::CMD_PTR_W-1:0])
    else $error("command queue pointers disagree with count");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

endmodule

>>> rtl/hcbp_back.sv
// Back end: bit accumulator that appends codes, emits bytes and tails, and buffers result words.
`timescale 1ns / 1ps

module hcbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  hcbp_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output hcbp_pkg::out_word_t out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EMIT = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic [hcbp_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [hcbp_pkg::TOT_W-1:0]  tot_q, tot_d;
  logic [hcbp_pkg::PEND_W-1:0] pend;
  logic [hcbp_pkg::ACC_W-1:0]  emit_shift;
  logic [hcbp_pkg::TOT_W-1:0]  tot_less8;
  logic [hcbp_pkg::BYTE_W-1:0] pad_byte;

  hcbp_pkg::out_word_t ofifo_q [hcbp_pkg::OUT_DEPTH];
  logic [hcbp_pkg::OUT_PTR_W-1:0] owr_q, ord_q;
  logic [hcbp_pkg::OUT_PTR_W:0]   ocnt_q;
  logic                ofull;
  logic                opush;
  logic                opop;
  hcbp_pkg::out_word_t oword;

  // Only the low tot_q bits are still pending; the rest were already sent.
  assign pend = acc_q[hcbp_pkg::PEND_W-1:0] &
                (hcbp_pkg::PEND_W'(7'h7f) >> (3'd7 - tot_q[2:0]));
  assign tot_less8  = tot_q - hcbp_pkg::TOT_W'(8);
  assign emit_shift = acc_q >> tot_less8;
  assign pad_byte   = {pend, 1'b0} << (3'd7 - tot_q[2:0]);

  assign ofull   = (ocnt_q == (hcbp_pkg::OUT_PTR_W+1)'(hcbp_pkg::OUT_DEPTH));
  assign empty_o = (ocnt_q == '0);
  assign opop    = pop_i && !empty_o;
  assign out_o   = ofifo_q[ord_q];

  assign cmd_pop_o = (st_q == ST_IDLE) && !cmd_empty_i;

  always_comb begin
    st_d  = st_q;
    acc_d = acc_q;
    tot_d = tot_q;
    opush = 1'b0;
    oword = '0;
    case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.is_flush) begin
            st_d = (tot_q != '0) ? ST_PAD : ST_TAIL;
          end else begin
            acc_d = (hcbp_pkg::ACC_W'(pend) << cmd_i.len) | hcbp_pkg::ACC_W'(cmd_i.code);
            tot_d = tot_q + hcbp_pkg::TOT_W'(cmd_i.len);
            if (tot_d >= hcbp_pkg::TOT_W'(8)) begin
              st_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        oword.out_byte   = emit_shift[hcbp_pkg::BYTE_W-1:0];
        oword.valid_bits = 4'd8;
        oword.last       = (tot_less8 < hcbp_pkg::TOT_W'(8));
        if (!ofull) begin
          opush = 1'b1;
          tot_d = tot_less8;
          if (oword.last) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        oword.out_byte   = pad_byte;
        oword.valid_bits = {1'b0, tot_q[2:0]};
        if (!ofull) begin
          opush = 1'b1;
          st_d  = ST_TAIL;
        end
      end
      ST_TAIL: begin
        oword.is_tail_info = 1'b1;
        oword.valid_bits   = {1'b0, tot_q[2:0]};
        oword.last         = 1'b1;
        if (!ofull) begin
          opush = 1'b1;
          acc_d = '0;
          tot_d = '0;
          st_d  = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ofifo_q[owr_q] <= oword;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      acc_q  <= '0;
      tot_q  <= '0;
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      st_q  <= st_d;
      acc_q <= acc_d;
      tot_q <= tot_d;
      if (opush) begin
        owr_q <= owr_q + 1'b1;
      end
      if (opop) begin
        ord_q <= ord_q + 1'b1;
      end
      if (opush && !opop) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (opop && !opush) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  a_idle_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (tot_q < hcbp_pkg::TOT_W'(8)))
    else $error("idle with a full byte still pending");

  a_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (tot_q >= hcbp_pkg::TOT_W'(8)))
    else $error("emitting without a complete byte");

  a_tail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TAIL && !ofull) |=> (tot_q == '0 && st_q == ST_IDLE))
    else $error("flush tail did not clear the accumulator");

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= (hcbp_pkg::OUT_PTR_W+1)'(hcbp_pkg::OUT_DEPTH))
    else $error("result buffer count overflow");

endmodule

>>> rtl/huffman_code_bit_packer.sv
// Top level of the static-table Huffman encoder and bit packer.
//
// Input channel: a word is taken at a clock edge with push high and full low.
// Load words write one code table entry; encode words append a symbol's code
// to the bit accumulator; flush words pad and send any partial byte, then a
// tail word with its valid bit count. Result channel: the oldest result word
// sits on out_data_o while empty is low and leaves at an edge with pop high.
// A word passes the front stage (table read); encodes with a code and flushes
// then wait in a four-entry command queue. The accumulator appends a code and
// then emits each completed byte in turn; a flush passes the pad state when a
// partial byte is pending, then the tail state. A load only writes the table.
// The front takes one word per cycle while the command queue has room. Loads
// never reach the accumulator and encodes that complete no byte leave it idle,
// so those stream at full rate; each emitted byte holds it in the emit state.
// Reset clears the table valid bits at once, so every symbol starts without a
// code, and empties the accumulator and both queues. When the receiver stops
// popping, the four-entry result buffer fills, the accumulator halts, the
// command queue fills behind it and full rises.
`timescale 1ns / 1ps

module huffman_code_bit_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hcbp_pkg::in_word_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output hcbp_pkg::out_word_t out_data_o
);

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  hcbp_pkg::cmd_t cmd_in;
  hcbp_pkg::cmd_t cmd_out;

  hcbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_i       (in_data_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  hcbp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  hcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_data_o)
  );

endmodule
